[rtl/core/rpt_pkg.sv]
package rpt_pkg;

  // Default sizes of the datapath
  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned ROT_WIDTH_DEF   = 18;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // Spatial dimensions: one lane per output coordinate
  localparam int unsigned NUM_DIM   = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW_0 = 3'd0,
    REG_ROT_ROW_1 = 3'd1,
    REG_ROT_ROW_2 = 3'd2,
    REG_TRANS_X   = 3'd3,
    REG_TRANS_Y   = 3'd4,
    REG_TRANS_Z   = 3'd5
  } rpt_reg_e;

  // Stage controls handed from the pipeline control to each lane
  typedef struct packed {
    logic load_b;  // products stage takes a new word
    logic load_c;  // rounding stage takes a new word
    logic fwd_b;   // word in the products stage is a forward transform
  } rpt_lane_ctrl_t;

endpackage

[rtl/core/rpt_lane.sv]
module rpt_lane import rpt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned ROT_WIDTH   = ROT_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  rpt_lane_ctrl_t                         ctrl_i,
  input  logic [NUM_DIM-1:0][ROT_WIDTH-1:0]      coef_i,
  input  logic [NUM_DIM-1:0][COORD_WIDTH:0]      vec_i,
  input  logic [COORD_WIDTH-1:0]                 trans_i,
  output logic [COORD_WIDTH-1:0]                 value_o,
  output logic                                   sat_o
);

  localparam int unsigned PW   = ROT_WIDTH + COORD_WIDTH + 1;
  localparam int unsigned SUMW = PW + 2;
  localparam int unsigned SHW  = SUMW - FRAC_BITS;
  localparam int unsigned ADW  = ((SHW > COORD_WIDTH) ? SHW : COORD_WIDTH) + 1;
  localparam int unsigned TOPW = ADW - COORD_WIDTH + 1;

  logic signed [PW-1:0]   prod_d [NUM_DIM];
  logic signed [PW-1:0]   prod_q [NUM_DIM];
  logic signed [SUMW-1:0] sum_d;
  logic signed [SHW-1:0]  rnd_d;
  logic signed [SHW-1:0]  rnd_q;
  logic                   fwd_q;
  logic signed [ADW-1:0]  adj;
  logic [TOPW-1:0]        adj_top;
  logic                   in_range;

  // Exact products of the row entries and the vector
  always_comb begin
    for (int j = 0; j < NUM_DIM; j++) begin
      prod_d[j] = PW'($signed(coef_i[j])) * PW'($signed(vec_i[j]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_b) begin
      for (int j = 0; j < NUM_DIM; j++) begin
        prod_q[j] <= prod_d[j];
      end
    end
  end

  // Exact sum, plus half an LSB, then floor to the output fraction
  always_comb begin
    sum_d = SUMW'(prod_q[0]) + SUMW'(prod_q[1]) + SUMW'(prod_q[2])
          + (SUMW'(1) <<< (FRAC_BITS - 1));
    rnd_d = sum_d[SUMW-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_c) begin
      rnd_q <= rnd_d;
      fwd_q <= ctrl_i.fwd_b;
    end
  end

  // Forward mode adds the translation after rounding; then saturate
  always_comb begin
    adj      = ADW'(rnd_q) + (fwd_q ? ADW'($signed(trans_i)) : '0);
    adj_top  = adj[ADW-1:COORD_WIDTH-1];
    in_range = (adj_top == '0) || (adj_top == '1);
    sat_o    = ~in_range;
    value_o  = in_range ? adj[COORD_WIDTH-1:0]
                        : {adj[ADW-1], {(COORD_WIDTH-1){~adj[ADW-1]}}};
  end

endmodule

[rtl/core/rpt_merge.sv]
module rpt_merge import rpt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [NUM_DIM-1:0][COORD_WIDTH-1:0]  lane_val_i,
  input  logic [NUM_DIM-1:0]                   lane_sat_i,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((NUM_DIM*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic [0:0]                           m_axis_tuser
);

  localparam int unsigned ODW = ((NUM_DIM * COORD_WIDTH + 7) / 8) * 8;

  logic           valid_q;
  logic           load;
  logic [ODW-1:0] data_q;
  logic           sat_q;

  // Output register frees as soon as the held word is taken
  assign ready_o = ~valid_q | m_axis_tready;
  assign load    = valid_i & ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Pack the three lanes, x lowest, and OR their clip flags
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= ODW'(lane_val_i);
      sat_q  <= |lane_sat_i;
    end
  end

  assign m_axis_tvalid   = valid_q;
  assign m_axis_tdata    = data_q;
  assign m_axis_tuser[0] = sat_q;

endmodule

[rtl/core/rigid_point_transform_top.sv]
// Rigid 3D point transform, one point per word. Forward mode (tuser = 0)
// gives R*p + t, inverse mode (tuser = 1) gives R^T * (p - t), with each
// coordinate rounded half up to Q15.16 and saturated; m_axis_tuser flags
// any clipped coordinate. Three lanes, one per output coordinate, each
// with three multipliers, run in a four-register pipeline (input, products,
// rounded sum, output), so a new point is taken every cycle while the
// output is not stalled, and its result passes through those registers in
// that order to m_axis_tvalid. R and t come from the config port; write them
// only while no point is in flight. Reset loads the identity transform.
module rigid_point_transform_top import rpt_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned ROT_WIDTH   = ROT_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [((NUM_DIM*ROT_WIDTH > COORD_WIDTH) ? NUM_DIM*ROT_WIDTH
                 : COORD_WIDTH)-1:0] cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // in_x, in_y, in_z from bit 0 up, zero padded to bytes
  input  logic [((NUM_DIM*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic [0:0]           s_axis_tuser,
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_x, out_y, out_z from bit 0 up, zero padded to bytes
  output logic [((NUM_DIM*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // saturated
  output logic [0:0]           m_axis_tuser
);

  localparam int unsigned ROW_W = NUM_DIM * ROT_WIDTH;

  logic [NUM_DIM-1:0][ROW_W-1:0]        rot_q;
  logic [NUM_DIM-1:0][COORD_WIDTH-1:0]  trans_q;

  logic                                 va_q, vb_q, vc_q;
  logic                                 inv_a_q, inv_b_q;
  logic                                 ready_a, ready_b, ready_c;
  logic                                 ready_c_merge;
  logic                                 load_a;
  logic [NUM_DIM-1:0][COORD_WIDTH:0]    vec_d, vec_q;
  logic [NUM_DIM-1:0][NUM_DIM-1:0][ROT_WIDTH-1:0] coef;
  rpt_lane_ctrl_t                       lane_ctrl;
  logic [NUM_DIM-1:0][COORD_WIDTH-1:0]  lane_val;
  logic [NUM_DIM-1:0]                   lane_sat;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_DIM; i++) begin
        rot_q[i]   <= ROW_W'(1) << (FRAC_BITS + i * ROT_WIDTH);
        trans_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (rpt_reg_e'(cfg_idx_i))
        REG_ROT_ROW_0: rot_q[0]   <= cfg_data_i[ROW_W-1:0];
        REG_ROT_ROW_1: rot_q[1]   <= cfg_data_i[ROW_W-1:0];
        REG_ROT_ROW_2: rot_q[2]   <= cfg_data_i[ROW_W-1:0];
        REG_TRANS_X:   trans_q[0] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_TRANS_Y:   trans_q[1] <= cfg_data_i[COORD_WIDTH-1:0];
        REG_TRANS_Z:   trans_q[2] <= cfg_data_i[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: each stage moves when the next one can take it
  assign ready_c       = ready_c_merge;
  assign ready_b       = ~vc_q | ready_c;
  assign ready_a       = ~vb_q | ready_b;
  assign s_axis_tready = ~va_q | ready_a;
  assign load_a        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (s_axis_tready) va_q <= s_axis_tvalid;
      if (ready_a)       vb_q <= va_q;
      if (ready_b)       vc_q <= vb_q;
    end
  end

  // Input stage: widen p, subtract t in inverse mode
  always_comb begin
    for (int j = 0; j < NUM_DIM; j++) begin
      vec_d[j] = {s_axis_tdata[j*COORD_WIDTH+COORD_WIDTH-1],
                  s_axis_tdata[j*COORD_WIDTH +: COORD_WIDTH]}
               - (s_axis_tuser[0] ? {trans_q[j][COORD_WIDTH-1], trans_q[j]}
                                  : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_a) begin
      vec_q   <= vec_d;
      inv_a_q <= s_axis_tuser[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (va_q & ready_a) begin
      inv_b_q <= inv_a_q;
    end
  end

  // Lane i uses row i of R, or column i in inverse mode
  always_comb begin
    for (int i = 0; i < NUM_DIM; i++) begin
      for (int j = 0; j < NUM_DIM; j++) begin
        coef[i][j] = inv_a_q ? rot_q[j][i*ROT_WIDTH +: ROT_WIDTH]
                             : rot_q[i][j*ROT_WIDTH +: ROT_WIDTH];
      end
    end
  end

  assign lane_ctrl.load_b = va_q & ready_a;
  assign lane_ctrl.load_c = vb_q & ready_b;
  assign lane_ctrl.fwd_b  = ~inv_b_q;

  for (genvar i = 0; i < NUM_DIM; i++) begin : g_lane
    rpt_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .ROT_WIDTH   (ROT_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lane_ctrl),
      .coef_i  (coef[i]),
      .vec_i   (vec_q),
      .trans_i (trans_q[i]),
      .value_o (lane_val[i]),
      .sat_o   (lane_sat[i])
    );
  end

  rpt_merge #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (vc_q),
    .ready_o       (ready_c_merge),
    .lane_val_i    (lane_val),
    .lane_sat_i    (lane_sat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
